### design/mcic_pkg.sv
package mcic_pkg;

  localparam int unsigned ChW        = 8;
  localparam int unsigned NumColor   = 3;
  localparam int unsigned ChMax      = 255;
  localparam int unsigned ChMaxSq    = 65025;
  localparam int unsigned RecipSq    = 66051;
  localparam int unsigned RecipSqSh  = 32;
  localparam int unsigned RecipCh    = 65793;
  localparam int unsigned RecipChSh  = 24;
  localparam int unsigned CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBackAlpha = 2'd0,
    CfgBackRed   = 2'd1,
    CfgBackGreen = 2'd2,
    CfgBackBlue  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ChW-1:0] image_alpha;
    logic [ChW-1:0] image_red;
    logic [ChW-1:0] image_green;
    logic [ChW-1:0] image_blue;
    logic [ChW-1:0] mask_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0] result_alpha;
    logic [ChW-1:0] result_red;
    logic [ChW-1:0] result_green;
    logic [ChW-1:0] result_blue;
  } pix_out_t;

endpackage

### design/masked_color_image_compositor_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         start_i / busy_o   pixel_i  (pix_in_t)
// result    out        done_o             result_o (pix_out_t)
// config    in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// Four register stages: blend products, mask product, reciprocal estimate,
// remainder correction with saturation into the output register.
// One item per clock; each result is taken from the output register.
// busy_o stays low: the receiver cannot stall, so nothing ever backs up.
// Reset clears the valid bits and the background color to zero.
module masked_color_image_compositor_unit
  import mcic_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  pix_in_t             pixel_i,
  output logic                done_o,
  output pix_out_t            result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ChW-1:0]      cfg_wdata_i
);

  logic [ChW-1:0] bg_a_q;
  logic [ChW-1:0] bg_c_q [NumColor];

  logic           v1_q, v2_q, v3_q, done_q;

  // stage 1: blend over background
  logic [15:0]    over_d [NumColor];
  logic [15:0]    over_q [NumColor];
  logic [8:0]     asum_d, asum_q;
  logic [ChW-1:0] ma1_q;

  // stage 2: mask product
  logic [23:0]    prod_d [NumColor];
  logic [23:0]    prod_q [NumColor];
  logic [16:0]    aprod_d, aprod_q;

  // stage 3: reciprocal estimate
  logic [40:0]    est_full [NumColor];
  logic [ChW-1:0] est_d [NumColor];
  logic [ChW-1:0] est_q [NumColor];
  logic [23:0]    prod3_q [NumColor];
  logic [33:0]    aest_full;
  logic [8:0]     aest_d, aest_q;
  logic [16:0]    aprod3_q;

  // stage 4: correction
  logic [23:0]    rem   [NumColor];
  logic [8:0]     quo   [NumColor];
  logic [ChW-1:0] res_c [NumColor];
  logic [16:0]    arem;
  logic [9:0]     aquo;
  pix_out_t       res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_a_q <= '0;
      for (int i = 0; i < NumColor; i++) bg_c_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBackAlpha: bg_a_q    <= cfg_wdata_i;
        CfgBackRed:   bg_c_q[0] <= cfg_wdata_i;
        CfgBackGreen: bg_c_q[1] <= cfg_wdata_i;
        CfgBackBlue:  bg_c_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [ChW-1:0] img_c [NumColor];
  logic [ChW-1:0] inv_ia;

  always_comb begin
    img_c[0] = pixel_i.image_red;
    img_c[1] = pixel_i.image_green;
    img_c[2] = pixel_i.image_blue;
    inv_ia   = ChW'(ChMax) - pixel_i.image_alpha;
    for (int i = 0; i < NumColor; i++) begin
      over_d[i] = 16'(bg_c_q[i]) * 16'(inv_ia) + 16'(img_c[i]) * 16'(pixel_i.image_alpha);
    end
    asum_d = 9'(bg_a_q) + 9'(pixel_i.image_alpha);
  end

  always_comb begin
    for (int i = 0; i < NumColor; i++) begin
      prod_d[i] = 24'(over_q[i]) * 24'(ma1_q);
    end
    aprod_d = 17'(asum_q) * 17'(ma1_q);
  end

  always_comb begin
    for (int i = 0; i < NumColor; i++) begin
      est_full[i] = 41'(prod_q[i]) * 41'(RecipSq);
      est_d[i]    = est_full[i][RecipSqSh+ChW-1:RecipSqSh];
    end
    aest_full = 34'(aprod_q) * 34'(RecipCh);
    aest_d    = aest_full[RecipChSh+8:RecipChSh];
  end

  always_comb begin
    for (int i = 0; i < NumColor; i++) begin
      rem[i]   = prod3_q[i] - 24'(est_q[i]) * 24'(ChMaxSq);
      quo[i]   = 9'(est_q[i]) + 9'(rem[i] >= 24'(ChMaxSq));
      res_c[i] = quo[i][8] ? ChW'(ChMax) : quo[i][ChW-1:0];
    end
    arem = aprod3_q - 17'(aest_q) * 17'(ChMax);
    aquo = 10'(aest_q) + 10'(arem >= 17'(ChMax));
    res_d.result_alpha = (aquo > 10'(ChMax)) ? ChW'(ChMax) : aquo[ChW-1:0];
    res_d.result_red   = res_c[0];
    res_d.result_green = res_c[1];
    res_d.result_blue  = res_c[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    over_q   <= over_d;
    asum_q   <= asum_d;
    ma1_q    <= pixel_i.mask_alpha;
    prod_q   <= prod_d;
    aprod_q  <= aprod_d;
    est_q    <= est_d;
    aest_q   <= aest_d;
    prod3_q  <= prod_q;
    aprod3_q <= aprod_q;
    res_q    <= res_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##3 done_o)
    else $error("item did not reach the output after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> ##3 !done_o)
    else $error("result without a started item");

  a_est_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (rem[0] < 24'(2*ChMaxSq)) && (rem[1] < 24'(2*ChMaxSq))
             && (rem[2] < 24'(2*ChMaxSq)))
    else $error("color quotient estimate off by more than one");

  a_est_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> arem < 17'(2*ChMax))
    else $error("alpha quotient estimate off by more than one");

endmodule
